FILE: rtl/core/gert_pkg.sv
// ----------------------------------------------------------------------------
// gert_pkg: shared types and constants for the reservation table
// Cell codes, request function codes, field widths and register indexes.
// ----------------------------------------------------------------------------
package gert_pkg;

  localparam int FUNC_W    = 2;
  localparam int COORD_W   = 6;
  localparam int DIM_W     = 7;
  localparam int CNT_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  typedef enum logic [1:0] {
    CELL_FREE     = 2'd0,
    CELL_BLOCKED  = 2'd1,
    CELL_EXPLORED = 2'd2,
    CELL_RESERVED = 2'd3
  } cell_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD  = 2'd0,
    FN_START = 2'd1,
    FN_PICK  = 2'd2,
    FN_MARK  = 2'd3
  } func_t;

endpackage

FILE: rtl/core/gert_if.sv
// ----------------------------------------------------------------------------
// gert_if: channel interfaces of the reservation table
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface gert_req_if;
  import gert_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic               load_blocked;
  modport source (output valid, func, row, col, load_blocked, input ready);
  modport sink   (input valid, func, row, col, load_blocked, output ready);
endinterface

interface gert_rsp_if;
  import gert_pkg::*;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [COORD_W-1:0] next_row;
  logic [COORD_W-1:0] next_col;
  logic               complete;
  logic [CNT_W-1:0]   explored_count;
  modport source (output valid, ok, next_row, next_col, complete, explored_count,
                  input ready);
  modport sink   (input valid, ok, next_row, next_col, complete, explored_count,
                  output ready);
endinterface

interface gert_cfg_if;
  import gert_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [DIM_W-1:0]     data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

FILE: rtl/core/gert_cell_ram.sv
// ----------------------------------------------------------------------------
// gert_cell_ram: cell state memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gert_cell_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  gert_pkg::cell_t     wr_data,
  input  logic [ADDR_W-1:0]   rd_addr,
  output gert_pkg::cell_t     rd_data
);
  import gert_pkg::*;

  cell_t mem [DEPTH];
  cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/grid_exploration_reservation_table_top.sv
// ----------------------------------------------------------------------------
// grid_exploration_reservation_table_top: grid exploration reservation table
// Holds the state of every grid cell and the free and explored cell counts.
//
// Usage: each request on in_req carries a function (load, start, pick, mark),
// a row and a column, plus the blocked flag for a load. Every request gives
// exactly one response on out_rsp with a success flag, the reserved neighbor
// (or the request coordinates), the completion flag and the explored count.
// Grid size registers are written on cfg_wr (index 0 rows, 1 columns) and
// cfg_wr is always ready; the user must write them only while the block is
// idle, which the block itself does not enforce. A sequencer around the one
// cell memory handles one request at a time: load and out-of-range requests
// pass S_PROBE and S_DONE, start and mark S_PROBE, S_EVAL and S_DONE, and a
// pick probes neighbors in turn, each one in range needing a registered
// memory read and an S_EVAL step. in_req is ready only in the idle state.
// The response sits in an output register; a new request is taken while it
// waits, but that request's result stalls until out_rsp.ready frees it.
// Reset clears the counts, the control state and sets a 64 by 64 grid; cell
// memory contents are not cleared and each cell must be loaded before use.
// ----------------------------------------------------------------------------
module grid_exploration_reservation_table_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  gert_req_if.sink  in_req,
  gert_rsp_if.source out_rsp,
  gert_cfg_if.sink  cfg_wr
);
  import gert_pkg::*;

  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int MUL_W   = ADDR_W + DIM_W + 1;
  localparam int RLIM_W  = $clog2(MAX_ROWS + 1);
  localparam int CLIM_W  = $clog2(MAX_COLS + 1);
  localparam int LIM_W0  = (RLIM_W > CLIM_W) ? RLIM_W : CLIM_W;
  localparam int LIM_W   = (LIM_W0 > DIM_W) ? LIM_W0 : DIM_W;
  localparam logic [LIM_W-1:0] ROW_CAP = LIM_W'(MAX_ROWS);
  localparam logic [LIM_W-1:0] COL_CAP = LIM_W'(MAX_COLS);
  localparam logic [1:0] PROBE_LAST = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PROBE = 4'b0010,
    S_EVAL  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  func_t              func_r, func_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic               blk_r, blk_nxt;
  logic               in_range_r, in_range_nxt;
  logic [1:0]         probe_r, probe_nxt;
  logic               ok_r, ok_nxt;
  logic [COORD_W-1:0] res_row_r, res_row_nxt;
  logic [COORD_W-1:0] res_col_r, res_col_nxt;
  logic [CNT_W-1:0]   free_total_r, free_total_nxt;
  logic [CNT_W-1:0]   explored_total_r, explored_total_nxt;
  logic [DIM_W-1:0]   rows_cfg_r, cols_cfg_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [COORD_W-1:0] out_row_r, out_row_nxt;
  logic [COORD_W-1:0] out_col_r, out_col_nxt;
  logic               out_complete_r, out_complete_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;

  logic [LIM_W-1:0]   nr_lim, nc_lim;
  logic [DIM_W-1:0]   row_inc, col_inc;
  logic [DIM_W-1:0]   cand_row, cand_col;
  logic               cand_ok;
  logic [ADDR_W-1:0]  cell_addr;
  logic               mem_wr_en;
  cell_t              mem_wr_data;
  cell_t              mem_rd_data;

  assign nr_lim = (LIM_W'(rows_cfg_r) > ROW_CAP) ? ROW_CAP : LIM_W'(rows_cfg_r);
  assign nc_lim = (LIM_W'(cols_cfg_r) > COL_CAP) ? COL_CAP : LIM_W'(cols_cfg_r);

  assign row_inc = {1'b0, row_r} + DIM_W'(1);
  assign col_inc = {1'b0, col_r} + DIM_W'(1);

  always_comb begin
    cand_row = {1'b0, row_r};
    cand_col = {1'b0, col_r};
    cand_ok  = 1'b1;
    if (func_r == FN_PICK) begin
      case (probe_r)
        2'd0: begin
          cand_row = row_inc;
          cand_ok  = LIM_W'(row_inc) < nr_lim;
        end
        2'd1: begin
          cand_row = {1'b0, row_r - COORD_W'(1)};
          cand_ok  = row_r != '0;
        end
        2'd2: begin
          cand_col = col_inc;
          cand_ok  = LIM_W'(col_inc) < nc_lim;
        end
        default: begin
          cand_col = {1'b0, col_r - COORD_W'(1)};
          cand_ok  = col_r != '0;
        end
      endcase
    end
  end

  assign cell_addr = ADDR_W'(MUL_W'(cand_row) * MUL_W'(MAX_COLS) + MUL_W'(cand_col));

  gert_cell_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (cell_addr),
    .wr_data (mem_wr_data),
    .rd_addr (cell_addr),
    .rd_data (mem_rd_data)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    state_nxt          = state_r;
    func_nxt           = func_r;
    row_nxt            = row_r;
    col_nxt            = col_r;
    blk_nxt            = blk_r;
    in_range_nxt       = in_range_r;
    probe_nxt          = probe_r;
    ok_nxt             = ok_r;
    res_row_nxt        = res_row_r;
    res_col_nxt        = res_col_r;
    free_total_nxt     = free_total_r;
    explored_total_nxt = explored_total_r;
    mem_wr_en          = 1'b0;
    mem_wr_data        = CELL_EXPLORED;
    out_valid_nxt      = out_valid_r;
    out_ok_nxt         = out_ok_r;
    out_row_nxt        = out_row_r;
    out_col_nxt        = out_col_r;
    out_complete_nxt   = out_complete_r;
    out_count_nxt      = out_count_r;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          func_nxt     = func_t'(in_req.func);
          row_nxt      = in_req.row;
          col_nxt      = in_req.col;
          blk_nxt      = in_req.load_blocked;
          in_range_nxt = (LIM_W'(in_req.row) < nr_lim) && (LIM_W'(in_req.col) < nc_lim);
          probe_nxt    = '0;
          ok_nxt       = 1'b0;
          res_row_nxt  = in_req.row;
          res_col_nxt  = in_req.col;
          state_nxt    = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!in_range_r) begin
          state_nxt = S_DONE;
        end else begin
          case (func_r)
            FN_LOAD: begin
              mem_wr_en   = 1'b1;
              mem_wr_data = blk_r ? CELL_BLOCKED : CELL_FREE;
              if (!blk_r && !(&free_total_r)) begin
                free_total_nxt = free_total_r + CNT_W'(1);
              end
              ok_nxt    = 1'b1;
              state_nxt = S_DONE;
            end
            FN_PICK: begin
              if (cand_ok) begin
                state_nxt = S_EVAL;
              end else if (probe_r == PROBE_LAST) begin
                state_nxt = S_DONE;
              end else begin
                probe_nxt = probe_r + 2'd1;
              end
            end
            default: begin
              state_nxt = S_EVAL;
            end
          endcase
        end
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        case (func_r)
          FN_START: begin
            if (mem_rd_data == CELL_FREE) begin
              mem_wr_en = 1'b1;
              ok_nxt    = 1'b1;
              if (!(&explored_total_r)) begin
                explored_total_nxt = explored_total_r + CNT_W'(1);
              end
            end
          end
          FN_MARK: begin
            if (mem_rd_data == CELL_RESERVED) begin
              mem_wr_en = 1'b1;
              ok_nxt    = 1'b1;
              if (!(&explored_total_r)) begin
                explored_total_nxt = explored_total_r + CNT_W'(1);
              end
            end else if (mem_rd_data == CELL_EXPLORED) begin
              ok_nxt = 1'b1;
            end
          end
          FN_PICK: begin
            if (mem_rd_data == CELL_FREE) begin
              mem_wr_en   = 1'b1;
              mem_wr_data = CELL_RESERVED;
              ok_nxt      = 1'b1;
              res_row_nxt = cand_row[COORD_W-1:0];
              res_col_nxt = cand_col[COORD_W-1:0];
            end else if (probe_r != PROBE_LAST) begin
              probe_nxt = probe_r + 2'd1;
              state_nxt = S_PROBE;
            end
          end
          default: begin
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt    = 1'b1;
          out_ok_nxt       = ok_r;
          out_row_nxt      = res_row_r;
          out_col_nxt      = res_col_r;
          out_complete_nxt = explored_total_r == free_total_r;
          out_count_nxt    = explored_total_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      out_valid_r      <= 1'b0;
      free_total_r     <= '0;
      explored_total_r <= '0;
      rows_cfg_r       <= DIM_RESET;
      cols_cfg_r       <= DIM_RESET;
    end else begin
      state_r          <= state_nxt;
      out_valid_r      <= out_valid_nxt;
      free_total_r     <= free_total_nxt;
      explored_total_r <= explored_total_nxt;
      if (cfg_wr.valid) begin
        case (cfg_wr.idx)
          CFG_ROWS: rows_cfg_r <= cfg_wr.data;
          CFG_COLS: cols_cfg_r <= cfg_wr.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r         <= func_nxt;
    row_r          <= row_nxt;
    col_r          <= col_nxt;
    blk_r          <= blk_nxt;
    in_range_r     <= in_range_nxt;
    probe_r        <= probe_nxt;
    ok_r           <= ok_nxt;
    res_row_r      <= res_row_nxt;
    res_col_r      <= res_col_nxt;
    out_ok_r       <= out_ok_nxt;
    out_row_r      <= out_row_nxt;
    out_col_r      <= out_col_nxt;
    out_complete_r <= out_complete_nxt;
    out_count_r    <= out_count_nxt;
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.ok             = out_ok_r;
  assign out_rsp.next_row       = out_row_r;
  assign out_rsp.next_col       = out_col_r;
  assign out_rsp.complete       = out_complete_r;
  assign out_rsp.explored_count = out_count_r;

`ifndef ASSERT_OFF
  a_explored_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (explored_total_r >= $past(explored_total_r)))
    else $error("explored count decreased");

  a_free_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (free_total_r >= $past(free_total_r)))
    else $error("free count decreased");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("response raised outside the done state");

  a_write_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (state_r == S_PROBE || state_r == S_EVAL))
    else $error("cell memory written while idle or done");
`endif

endmodule
